FILE: sv/pocsag_bch_codeword_corrector_defines.svh
// ----------------------------------------------------------------------------
// POCSAG BCH corrector assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, reset on rst_ni.
// ----------------------------------------------------------------------------
`ifndef POCSAG_BCH_CODEWORD_CORRECTOR_DEFINES_SVH
`define POCSAG_BCH_CODEWORD_CORRECTOR_DEFINES_SVH

// Same-cycle implication.
`define PCBCH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PCBCH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/pcbch_pkg.sv
// ----------------------------------------------------------------------------
// POCSAG BCH corrector package
// Syndrome width, per-bit syndrome table and decode table entry format.
// ----------------------------------------------------------------------------
package pcbch_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned SYN_W  = 11;   // 10-bit remainder + parity bit
  localparam logic [SYN_W-1:0] GEN_POLY   = 11'h769;
  localparam logic [SYN_W-1:0] PARITY_BIT = 11'h400;

  localparam logic [1:0] LVL_DETECT = 2'd0;
  localparam logic [1:0] LVL_RESET  = 2'd2;

  typedef logic [SYN_W-1:0] syn_t;
  typedef syn_t syn_tab_t [WORD_W];

  typedef enum logic [1:0] {
    LUT_NONE,
    LUT_SINGLE,
    LUT_DOUBLE
  } lut_kind_e;

  typedef struct packed {
    lut_kind_e         kind;
    logic [POS_W-1:0]  pos_b;
    logic [POS_W-1:0]  pos_a;
  } lut_entry_t;

  // Syndrome of a word with only bit i set. Bit 0 lies outside the BCH part
  // and only upsets parity; bit i>0 gives x^(i-1) mod g plus parity.
  function automatic syn_tab_t build_syn_tab();
    syn_tab_t tab;
    syn_t     r;
    tab[0] = PARITY_BIT;
    r = 11'd1;
    for (int i = 1; i < WORD_W; i++) begin
      tab[i] = r | PARITY_BIT;
      r = r << 1;
      if (r[SYN_W-1]) begin
        r = r ^ GEN_POLY;
      end
    end
    return tab;
  endfunction

  localparam syn_tab_t SYN_TAB = build_syn_tab();

endpackage

FILE: sv/pcbch_syndrome.sv
// ----------------------------------------------------------------------------
// POCSAG BCH syndrome
// XOR tree over the per-bit syndrome table: remainder by 0x769 plus parity.
// ----------------------------------------------------------------------------
module pcbch_syndrome
  import pcbch_pkg::*;
(
  input  logic [WORD_W-1:0] word_i,
  output syn_t              syn_o
);

  always_comb begin
    syn_o = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (word_i[i]) begin
        syn_o = syn_o ^ SYN_TAB[i];
      end
    end
  end

endmodule

FILE: sv/pcbch_table.sv
// ----------------------------------------------------------------------------
// POCSAG BCH decode table
// Syndrome-indexed memory of error positions, built by a sweep after reset.
// ----------------------------------------------------------------------------
module pcbch_table
  import pcbch_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rd_en_i,
  input  syn_t       rd_addr_i,
  output lut_entry_t rd_data_o,
  output logic       init_done_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_SINGLE,
    ST_PAIR,
    ST_DONE
  } fill_state_e;

  lut_entry_t mem_q [2**SYN_W];

  fill_state_e      state_q, state_d;
  syn_t             clr_q, clr_d;
  logic [POS_W-1:0] a_q, a_d;
  logic [POS_W-1:0] b_q, b_d;

  logic       wr_en;
  syn_t       wr_addr;
  lut_entry_t wr_data;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    a_d     = a_q;
    b_d     = b_q;
    wr_en   = 1'b0;
    wr_addr = clr_q;
    wr_data = '0;
    case (state_q)
      ST_CLEAR: begin
        wr_en = 1'b1;
        clr_d = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = ST_SINGLE;
          a_d     = '0;
        end
      end
      ST_SINGLE: begin
        wr_en   = 1'b1;
        wr_addr = SYN_TAB[a_q];
        wr_data = '{kind: LUT_SINGLE, pos_b: '0, pos_a: a_q};
        a_d     = a_q + 1'b1;
        if (&a_q) begin
          state_d = ST_PAIR;
          a_d     = '0;
          b_d     = POS_W'(1);
        end
      end
      ST_PAIR: begin
        wr_en   = 1'b1;
        wr_addr = SYN_TAB[a_q] ^ SYN_TAB[b_q];
        wr_data = '{kind: LUT_DOUBLE, pos_b: b_q, pos_a: a_q};
        if (&b_q) begin
          if (a_q == POS_W'(WORD_W - 2)) begin
            state_d = ST_DONE;
          end else begin
            a_d = a_q + 1'b1;
            b_d = a_q + POS_W'(2);
          end
        end else begin
          b_d = b_q + 1'b1;
        end
      end
      ST_DONE: begin
      end
      default: begin
        state_d = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      a_q     <= '0;
      b_q     <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      a_q     <= a_d;
      b_q     <= b_d;
    end
  end

  // Writes happen only while building, reads only once built: no overlap.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

  assign init_done_o = (state_q == ST_DONE);

endmodule

FILE: sv/pocsag_bch_codeword_corrector.sv
// ----------------------------------------------------------------------------
// POCSAG BCH(31,21) codeword corrector
// Checks a POCSAG codeword and repairs up to two flipped bits.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis_* takes one 32-bit codeword per beat (bits 31..1 the
//   BCH part, bit 0 even parity). Master stream m_axis_* gives one result
//   beat per codeword, in order: the repaired word in tdata, the
//   uncorrectable flag and the count of flipped bits in tuser.
//   cfg_* writes the 2-bit correction level (0 detect, 1 single, 2 or 3
//   double); the user must write it only while the block is idle, which
//   the block itself does not enforce. An accepted codeword passes the
//   table read stage, then the output register. Throughput: one codeword
//   per cycle while the receiver does not stall, set by the single read
//   port of the decode table, which is read once per codeword. After reset
//   the table is built (all entries cleared, single and pair entries
//   filled) with s_axis_tready low; config writes are taken throughout.
//   When the receiver stalls, the output register holds its beat, the table
//   read stage holds, and s_axis_tready falls once both are full.
// ----------------------------------------------------------------------------
`include "pocsag_bch_codeword_corrector_defines.svh"

module pocsag_bch_codeword_corrector
  import pcbch_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_data_i,     // [1:0] correction_level
  // codeword in
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [WORD_W-1:0] s_axis_tdata,   // [31:0] codeword
  // result out
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [WORD_W-1:0] m_axis_tdata,   // [31:0] repaired_word
  output logic [2:0]        m_axis_tuser    // [0] uncorrectable, [2:1] bits_flipped
);

  logic [1:0] lvl_q;

  syn_t       syn;
  lut_entry_t lut;
  logic       init_done;

  logic              in_acc;
  logic              s1_adv;
  logic              s1_valid_q;
  logic [WORD_W-1:0] s1_word_q;
  logic              s1_nz_q;

  logic              m_valid_q;
  logic [WORD_W-1:0] m_word_q;
  logic              m_bad_q;
  logic [1:0]        m_flips_q;

  logic [WORD_W-1:0] fix_mask;
  logic [1:0]        flips;

  // Config register, always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= LVL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      lvl_q <= cfg_data_i;
    end
  end

  pcbch_syndrome u_syndrome (
    .word_i (s_axis_tdata),
    .syn_o  (syn)
  );

  // Table read is enabled only on accept, so its data holds while stalled.
  pcbch_table u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (in_acc),
    .rd_addr_i   (syn),
    .rd_data_o   (lut),
    .init_done_o (init_done)
  );

  assign s1_adv        = !m_valid_q || m_axis_tready;
  assign s_axis_tready = init_done && (!s1_valid_q || s1_adv);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Stage 1: word waits alongside the table read. An empty stage takes a
  // beat even while the output register is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!s1_valid_q || s1_adv) begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_word_q <= s_axis_tdata;
      s1_nz_q   <= (syn != '0);
    end
  end

  // Level 0 never fixes; 1 fixes singles; 2 and 3 fix singles and doubles.
  always_comb begin
    fix_mask = '0;
    flips    = 2'd0;
    case (lut.kind)
      LUT_SINGLE: begin
        if (lvl_q != LVL_DETECT) begin
          fix_mask = WORD_W'(1) << lut.pos_a;
          flips    = 2'd1;
        end
      end
      LUT_DOUBLE: begin
        if (lvl_q[1]) begin
          fix_mask = (WORD_W'(1) << lut.pos_a) | (WORD_W'(1) << lut.pos_b);
          flips    = 2'd2;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s1_adv) begin
      m_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      m_word_q  <= s1_word_q ^ fix_mask;
      m_bad_q   <= s1_nz_q && (flips == 2'd0);
      m_flips_q <= flips;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_word_q;
  assign m_axis_tuser  = {m_flips_q, m_bad_q};

  `PCBCH_ASSERT_NOW(a_no_accept_while_building, in_acc, init_done,
                    "codeword accepted before decode table built")
  `PCBCH_ASSERT_NEXT(a_accept_fills_stage1, in_acc, s1_valid_q,
                     "accepted codeword lost from read stage")
  `PCBCH_ASSERT_NOW(a_flag_excludes_fix, m_axis_tvalid && m_axis_tuser[0],
                    m_axis_tuser[2:1] == 2'd0,
                    "uncorrectable beat reports flipped bits")
  `PCBCH_ASSERT_NOW(a_flip_count_range, m_axis_tvalid, m_axis_tuser[2:1] != 2'd3,
                    "flip count out of range")

endmodule

FILE: sim/pocsag_bch_codeword_corrector_checker.sv
// ----------------------------------------------------------------------------
// POCSAG BCH corrector result checker
// Watches the codeword, result and configuration channels. Predicts each
// repaired beat from the accepted codeword and the current correction level,
// and compares the result beats in order.
// ----------------------------------------------------------------------------
module pocsag_bch_corrector_checker
  import pcbch_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [1:0]        cfg_data_i,
  input  logic              s_tvalid_i,
  input  logic              s_tready_i,
  input  logic [WORD_W-1:0] s_tdata_i,
  input  logic              m_tvalid_i,
  input  logic              m_tready_i,
  input  logic [WORD_W-1:0] m_tdata_i,
  input  logic [2:0]        m_tuser_i,
  output int unsigned       pending_o,
  output int unsigned       error_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] LVL_SINGLE = 2'd1;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              uncorrectable;
    lut_kind_e         flips;
  } repair_t;

  repair_t     expected_repairs [$];
  logic [1:0]  level;
  int unsigned errors;

  // remainder of bits 31..1 by the generator, parity failure on top
  function automatic syn_t codeword_syndrome(logic [WORD_W-1:0] w);
    logic [WORD_W-2:0] rem;
    rem = w[WORD_W-1:1];
    for (int k = WORD_W - 2; k >= SYN_W - 1; k--) begin
      if (rem[k]) begin
        rem = rem ^ ((WORD_W-1)'(GEN_POLY) << (k - (SYN_W - 1)));
      end
    end
    return {^w, rem[SYN_W-2:0]};
  endfunction

  // syndrome is linear, so a flip pattern fits when its syndrome cancels
  function automatic repair_t predict_repair(logic [WORD_W-1:0] w, logic [1:0] lvl);
    repair_t r;
    syn_t    s;
    syn_t    bit_syn [WORD_W];
    logic    done;
    r.word          = w;
    r.uncorrectable = 1'b0;
    r.flips         = LUT_NONE;
    done            = 1'b0;
    s = codeword_syndrome(w);
    if (s == '0) begin
      return r;
    end
    for (int i = 0; i < WORD_W; i++) begin
      bit_syn[i] = codeword_syndrome(32'd1 << i);
    end
    if (lvl != LVL_DETECT) begin
      for (int i = 0; i < WORD_W && !done; i++) begin
        if ((s ^ bit_syn[i]) == '0) begin
          r.word  = w ^ (32'd1 << i);
          r.flips = LUT_SINGLE;
          done    = 1'b1;
        end
      end
    end
    // level 3 saturates to double-bit repair
    if (!done && lvl != LVL_DETECT && lvl != LVL_SINGLE) begin
      for (int i = 0; i < WORD_W && !done; i++) begin
        for (int j = i + 1; j < WORD_W && !done; j++) begin
          if ((s ^ bit_syn[i] ^ bit_syn[j]) == '0) begin
            r.word  = w ^ (32'd1 << i) ^ (32'd1 << j);
            r.flips = LUT_DOUBLE;
            done    = 1'b1;
          end
        end
      end
    end
    if (!done) begin
      r.uncorrectable = 1'b1;
    end
    return r;
  endfunction

  task automatic report(string what, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    errors++;
    $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    repair_t seen;
    repair_t want;
    if (!rst_ni) begin
      level = LVL_RESET;
      expected_repairs.delete();
      errors = 0;
      pending_o     <= 0;
      error_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        level = cfg_data_i;
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_repairs.push_back(predict_repair(s_tdata_i, level));
      end
      if (m_tvalid_i && m_tready_i) begin
        seen.word          = m_tdata_i;
        seen.uncorrectable = m_tuser_i[0];
        seen.flips         = lut_kind_e'(m_tuser_i[2:1]);
        if (expected_repairs.size() == 0) begin
          errors++;
          $display("%0t ns: result beat %h/%b with none expected, expected nothing",
                   $time, m_tdata_i, m_tuser_i);
        end else begin
          want = expected_repairs.pop_front();
          if (seen.word !== want.word) begin
            report("repaired_word", want.word, seen.word);
          end
          if (seen.uncorrectable !== want.uncorrectable) begin
            report("uncorrectable", want.uncorrectable, seen.uncorrectable);
          end
          if (seen.flips !== want.flips) begin
            report("bits_flipped", want.flips, seen.flips);
          end
        end
      end
      pending_o     <= expected_repairs.size();
      error_count_o <= errors;
    end
  end

endmodule

FILE: sim/tb_pocsag_bch_codeword_corrector.sv
// ----------------------------------------------------------------------------
// POCSAG BCH corrector testbench
// Drives codewords through the corrector at every correction level: a short
// directed set of edge words, then phases of random codewords carrying zero,
// one, two or more flipped bits. A checker beside the block predicts and
// compares every result beat; this module only makes stimulus and verdict.
// ----------------------------------------------------------------------------
module tb_pocsag_bch_codeword_corrector;
  timeunit 1ns;
  timeprecision 1ps;
  import pcbch_pkg::*;

  localparam int PHASES      = 10;
  localparam int PHASE_BEATS = 162;
  localparam int STEADY_PHASE = 5;   // phase run with no gaps on either side

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic [1:0]        cfg_data_i    = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [WORD_W-1:0] s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [WORD_W-1:0] m_axis_tdata;
  logic [2:0]        m_axis_tuser;

  int unsigned pending;
  int unsigned error_count;
  bit          steady = 1'b0;

  pocsag_bch_codeword_corrector uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  pocsag_bch_corrector_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .m_tuser_i     (m_axis_tuser),
    .pending_o     (pending),
    .error_count_o (error_count)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // receiver: back-pressure in about 7 beats of a hundred, none in the steady phase
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 7);
  end

  // Build a clean codeword: 21 message bits on top, BCH check bits below,
  // even parity in bit 0.
  function automatic logic [WORD_W-1:0] encode_codeword(logic [20:0] msg);
    logic [30:0]       rem;
    logic [WORD_W-1:0] w;
    rem = {msg, 10'd0};
    for (int k = 30; k >= 10; k--) begin
      if (rem[k]) begin
        rem = rem ^ (31'(GEN_POLY) << (k - 10));
      end
    end
    w    = {msg, rem[9:0], 1'b0};
    w[0] = ^w;
    return w;
  endfunction

  // flip n distinct bits anywhere in the word, parity bit included
  function automatic logic [WORD_W-1:0] flip_bits(logic [WORD_W-1:0] w, int n);
    logic [WORD_W-1:0] mask;
    int                hits;
    int                pos;
    mask = '0;
    hits = 0;
    while (hits < n) begin
      pos = $urandom_range(WORD_W - 1);
      if (!mask[pos]) begin
        mask[pos] = 1'b1;
        hits++;
      end
    end
    return w ^ mask;
  endfunction

  // mostly well-formed codewords with a few errors, some beyond repair, some noise
  function automatic logic [WORD_W-1:0] random_codeword();
    logic [WORD_W-1:0] cw;
    int                pick;
    cw   = encode_codeword(21'($urandom));
    pick = $urandom_range(99);
    if (pick < 25) begin
      return cw;
    end else if (pick < 55) begin
      return flip_bits(cw, 1);
    end else if (pick < 85) begin
      return flip_bits(cw, 2);
    end else if (pick < 95) begin
      return flip_bits(cw, $urandom_range(5, 3));
    end
    return $urandom;
  endfunction

  // one beat on the codeword stream; occasional one-cycle gap before it
  task automatic send_codeword(logic [WORD_W-1:0] w);
    if (!steady && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // drop valid and wait until every result is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_level(logic [1:0] lvl);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= lvl;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Hard stop. The slowest legal run, including the table build after reset,
  // ends long before this.
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [WORD_W-1:0] base;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // config is taken during the table build; data waits on tready
    write_level(LVL_RESET);

    // directed: all-zero and all-one words are clean, their neighbours are not
    base = encode_codeword(21'h15555a);
    send_codeword(32'h0000_0000);
    send_codeword(32'hffff_ffff);
    send_codeword(32'h0000_0001);
    send_codeword(32'h8000_0000);
    send_codeword(32'hffff_fffe);
    send_codeword(32'h7fff_ffff);
    send_codeword(32'h8000_0001);
    send_codeword(32'haaaa_aaaa);
    send_codeword(32'h5555_5555);
    send_codeword(encode_codeword(21'h000001));
    send_codeword(encode_codeword(21'h100000));
    send_codeword(base);
    // single flips: parity bit, lowest check bit, lowest message bit, top bit
    send_codeword(base ^ 32'h0000_0001);
    send_codeword(base ^ 32'h0000_0002);
    send_codeword(base ^ 32'h0000_0800);
    send_codeword(base ^ 32'h8000_0000);
    // double flips at the word and check-field edges
    send_codeword(base ^ 32'h8000_0001);
    send_codeword(base ^ 32'h0000_0003);
    send_codeword(base ^ 32'hc000_0000);
    send_codeword(base ^ 32'h0000_0402);
    // triple flips: beyond the code's reach
    send_codeword(base ^ 32'h8000_8001);
    send_codeword(base ^ 32'h0000_0007);

    // random phases: first every level in turn, detect-only and the
    // saturating level 3 among them, then random levels
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      write_level(ph < 4 ? 2'(ph) : 2'($urandom_range(3)));
      steady = (ph == STEADY_PHASE);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        send_codeword(random_codeword());
      end
    end
    steady = 1'b0;
    drain();

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
